FILE: rtl/core/obj_face_index_parser_defines.svh
// assertion macros for the obj face index parser
// used by the port checker; no other dependencies
`ifndef OBJ_FACE_INDEX_PARSER_DEFINES_SVH
`define OBJ_FACE_INDEX_PARSER_DEFINES_SVH

// clocked assertion, disabled while reset is held
`define OFIP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// clocked assertion that also runs during reset
`define OFIP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: rtl/core/ofip_pkg.sv
// shared types and constants for the obj face index parser
// no dependencies; imported by every module of the block
package ofip_pkg;

  // default index range in bits
  localparam int INDEX_BITS_DEF = 32;

  // field widths
  localparam int CH_W    = 8;
  localparam int IDX_W   = 32;
  localparam int OUT_DW  = 3 * IDX_W;
  localparam int OUT_UW  = 2;
  localparam int PH_W    = 3;

  // parse phase codes
  localparam logic [PH_W-1:0] PH_START  = 3'd0;
  localparam logic [PH_W-1:0] PH_NUM0   = 3'd1;
  localparam logic [PH_W-1:0] PH_SLASH1 = 3'd2;
  localparam logic [PH_W-1:0] PH_NUM1   = 3'd3;
  localparam logic [PH_W-1:0] PH_NUM2   = 3'd4;
  localparam logic [PH_W-1:0] PH_ERR    = 3'd5;

  // characters
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // one input beat
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            is_end;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] texcoord_index;
    logic [IDX_W-1:0] normal_index;
    logic             triple_valid;
    logic             parse_error;
    logic             last;
  } res_t;

endpackage

FILE: rtl/core/ofip_in_reg.sv
// input register of the obj face index parser: holds one character beat
// depends on ofip_pkg
module ofip_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ofip_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output ofip_pkg::item_t item
);
  import ofip_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // free when empty or when the held beat moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/core/ofip_parse.sv
// parse state and per-character step logic of the obj face index parser
// depends on ofip_pkg
module ofip_parse #(
  parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  ofip_pkg::item_t item,
  input  logic            advance,
  output logic            emit,
  output ofip_pkg::res_t  res
);
  import ofip_pkg::*;

  localparam int PROD_W = INDEX_BITS + 4;

  logic [PH_W-1:0]       phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] first_r, first_nxt;
  logic [INDEX_BITS-1:0] second_r, second_nxt;
  logic [INDEX_BITS-1:0] third_r, third_nxt;
  logic                  seen_r, seen_nxt;
  logic                  err_r, err_nxt;

  logic                  consume;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [INDEX_BITS-1:0] acc_sel;
  logic [INDEX_BITS-1:0] base;
  logic [PROD_W-1:0]     base_x;
  logic [PROD_W-1:0]     prod;
  logic                  ovf;
  logic [INDEX_BITS-1:0] sum;
  logic [63:0]           first_w, second_w, third_w;
  logic [IDX_W-1:0]      first_o, second_o, third_o;

  assign consume  = item_valid && advance;
  assign is_digit = item.ch inside {[CH_ZERO:CH_NINE]};
  assign digit    = is_digit ? item.ch[3:0] : 4'd0;

  // accumulator of the current number; a fresh number starts from zero
  always_comb begin
    case (phase_r)
      PH_NUM0: acc_sel = first_r;
      PH_NUM1: acc_sel = second_r;
      default: acc_sel = third_r;
    endcase
  end
  assign base = (phase_r == PH_SLASH1 || !seen_r) ? '0 : acc_sel;

  // times ten plus digit, overflow in the top four bits
  assign base_x = PROD_W'(base);
  assign prod   = (base_x << 3) + (base_x << 1) + PROD_W'(digit);
  assign ovf    = |prod[PROD_W-1:INDEX_BITS];
  assign sum    = prod[INDEX_BITS-1:0];

  // low 32 bits of each index
  assign first_w  = 64'(first_r);
  assign second_w = 64'(second_r);
  assign third_w  = 64'(third_r);
  assign first_o  = first_w[IDX_W-1:0];
  assign second_o = second_w[IDX_W-1:0];
  assign third_o  = third_w[IDX_W-1:0];

  // step logic
  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    res        = '0;

    if (item.is_end) begin
      // end marker: always one result, then back to reset state
      emit            = 1'b1;
      res.last        = 1'b1;
      res.parse_error = err_r;
      case (phase_r)
        PH_NUM0: begin
          if (seen_r) begin
            res.triple_valid   = 1'b1;
            res.vertex_index   = first_o;
            res.texcoord_index = first_o;
            res.normal_index   = first_o;
          end else begin
            res.parse_error = 1'b1;
          end
        end
        PH_SLASH1: begin
          res.parse_error = 1'b1;
        end
        PH_NUM1: begin
          if (seen_r) begin
            res.triple_valid   = 1'b1;
            res.vertex_index   = first_o;
            res.texcoord_index = second_o;
            res.normal_index   = IDX_W'(1);
          end else begin
            res.parse_error = 1'b1;
          end
        end
        PH_NUM2: begin
          if (seen_r) begin
            res.triple_valid   = 1'b1;
            res.vertex_index   = first_o;
            res.texcoord_index = second_o;
            res.normal_index   = third_o;
          end else begin
            res.parse_error = 1'b1;
          end
        end
        default: begin
        end
      endcase
      phase_nxt  = PH_START;
      first_nxt  = '0;
      second_nxt = '0;
      third_nxt  = '0;
      seen_nxt   = 1'b0;
      err_nxt    = 1'b0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (item.ch == CH_SPACE) begin
            first_nxt  = '0;
            second_nxt = '0;
            third_nxt  = '0;
            seen_nxt   = 1'b0;
            phase_nxt  = PH_NUM0;
          end else begin
            emit            = 1'b1;
            res.parse_error = 1'b1;
            err_nxt         = 1'b1;
            phase_nxt       = PH_ERR;
          end
        end
        PH_NUM0, PH_NUM1, PH_NUM2: begin
          if (is_digit) begin
            if (ovf) begin
              emit            = 1'b1;
              res.parse_error = 1'b1;
              err_nxt         = 1'b1;
              phase_nxt       = PH_ERR;
            end else begin
              seen_nxt = 1'b1;
              case (phase_r)
                PH_NUM0: first_nxt  = sum;
                PH_NUM1: second_nxt = sum;
                default: third_nxt  = sum;
              endcase
            end
          end else if (!seen_r) begin
            // leading spaces are skipped, anything else is a missing number
            if (item.ch != CH_SPACE) begin
              emit            = 1'b1;
              res.parse_error = 1'b1;
              err_nxt         = 1'b1;
              phase_nxt       = PH_ERR;
            end
          end else if (item.ch == CH_SPACE) begin
            // group closed by a space: emit and open the next group
            emit             = 1'b1;
            res.triple_valid = 1'b1;
            res.vertex_index = first_o;
            case (phase_r)
              PH_NUM0: begin
                res.texcoord_index = first_o;
                res.normal_index   = first_o;
              end
              PH_NUM1: begin
                res.texcoord_index = second_o;
                res.normal_index   = IDX_W'(1);
              end
              default: begin
                res.texcoord_index = second_o;
                res.normal_index   = third_o;
              end
            endcase
            first_nxt  = '0;
            second_nxt = '0;
            third_nxt  = '0;
            seen_nxt   = 1'b0;
            phase_nxt  = PH_NUM0;
          end else if (phase_r == PH_NUM2) begin
            // junk after the third index: the group still goes out, flagged
            emit               = 1'b1;
            res.triple_valid   = 1'b1;
            res.parse_error    = 1'b1;
            res.vertex_index   = first_o;
            res.texcoord_index = second_o;
            res.normal_index   = third_o;
            err_nxt            = 1'b1;
            phase_nxt          = PH_ERR;
          end else if (item.ch == CH_SLASH) begin
            if (phase_r == PH_NUM0) begin
              phase_nxt = PH_SLASH1;
            end else begin
              phase_nxt = PH_NUM2;
              seen_nxt  = 1'b0;
            end
          end else begin
            emit            = 1'b1;
            res.parse_error = 1'b1;
            err_nxt         = 1'b1;
            phase_nxt       = PH_ERR;
          end
        end
        PH_SLASH1: begin
          if (item.ch == CH_SLASH) begin
            // omitted texture index
            second_nxt = IDX_W'(1) > 0 ? INDEX_BITS'(1) : '0;
            third_nxt  = '0;
            seen_nxt   = 1'b0;
            phase_nxt  = PH_NUM2;
          end else if (item.ch == CH_SPACE) begin
            second_nxt = '0;
            seen_nxt   = 1'b0;
            phase_nxt  = PH_NUM1;
          end else if (is_digit && !ovf) begin
            second_nxt = sum;
            seen_nxt   = 1'b1;
            phase_nxt  = PH_NUM1;
          end else begin
            emit            = 1'b1;
            res.parse_error = 1'b1;
            err_nxt         = 1'b1;
            phase_nxt       = PH_ERR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      seen_r  <= 1'b0;
      err_r   <= 1'b0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
    end
  end

  // accumulators, cleared to zero by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      third_r  <= '0;
    end else if (consume) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
    end
  end

endmodule

FILE: rtl/core/ofip_out_reg.sv
// result register of the obj face index parser
// depends on ofip_pkg
module ofip_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  ofip_pkg::res_t res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output ofip_pkg::res_t out_res
);
  import ofip_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // slot can take a new result when empty or being drained
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/core/obj_face_index_parser.sv
// Face index parser for the argument text of an OBJ face line.
// Input channel: one character per beat in in_tdata; in_tlast marks the end
// of the text and carries no character. Each group " v", " v/t", " v//n" or
// " v/t/n" gives one result beat with the three indices in out_tdata and
// out_tuser[0] set; an omitted t or n reads as 1, a lone v fills all three.
// A bad character, a missing number or an index past INDEX_BITS gives one
// beat with out_tuser[1] set, and the rest of the line is skipped.
// The end beat always gives a result with out_tlast set, holding the last
// group if it completes one and the line's error flag.
// A result passes the input register, then the result register. Throughput:
// one character per cycle while the result register is free, set by the
// single parse step between the two registers.
// A stalled receiver holds the result register; the input register keeps
// accepting one more beat, and in_tready falls while both are full.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a line.
// depends on ofip_pkg, ofip_in_reg, ofip_parse, ofip_out_reg
module obj_face_index_parser #(
  parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ofip_pkg::CH_W-1:0]   in_tdata,   // [7:0] ch
  input  logic                        in_tlast,   // is_end
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ofip_pkg::OUT_DW-1:0] out_tdata,  // [31:0] vertex_index,
                                                  // [63:32] texcoord_index,
                                                  // [95:64] normal_index
  output logic [ofip_pkg::OUT_UW-1:0] out_tuser,  // [0] triple_valid,
                                                  // [1] parse_error
  output logic                        out_tlast   // last
);
  import ofip_pkg::*;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  slot_free;
  logic  emit;
  res_t  res;
  res_t  out_res;

  assign in_item.ch     = in_tdata;
  assign in_item.is_end = in_tlast;

  // input register
  ofip_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (slot_free),
    .item_valid (item_valid),
    .item       (item)
  );

  // parse step
  ofip_parse #(
    .INDEX_BITS (INDEX_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (slot_free),
    .emit       (emit),
    .res        (res)
  );

  // result register
  ofip_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (item_valid && slot_free && emit),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // result beat packing
  assign out_tdata = {out_res.normal_index, out_res.texcoord_index, out_res.vertex_index};
  assign out_tuser = {out_res.parse_error, out_res.triple_valid};
  assign out_tlast = out_res.last;

endmodule

FILE: rtl/core/ofip_checker.sv
// port checker for the obj face index parser, bound to the top level
// depends on ofip_pkg and obj_face_index_parser_defines.svh
`include "obj_face_index_parser_defines.svh"

module ofip_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ofip_pkg::OUT_DW-1:0] out_tdata,
  input logic [ofip_pkg::OUT_UW-1:0] out_tuser,
  input logic                        out_tlast
);
  import ofip_pkg::*;

  // a stalled result beat holds
  `OFIP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed while stalled")

  // indices read zero when no group is carried
  `OFIP_ASSERT(a_idx_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "indices nonzero without a group")

  // a result before the end beat carries a group or an error
  `OFIP_ASSERT(a_mid_kind, clk, rst_n, out_tvalid && !out_tlast |-> out_tuser != 2'b00, "empty result inside a line")

  // reset empties the result slot and frees the input side
  `OFIP_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

endmodule

bind obj_face_index_parser ofip_checker u_ofip_checker (.*);
